@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file of this core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bhs_pkg.sv @@
// ---------------------------------------------------------------------------
// bhs_pkg
// Shared types and codes of the sorted byte histogram core.
// ---------------------------------------------------------------------------
package bhs_pkg;

  // Command codes carried on the input tuser
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_COUNT = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  // Fixed field widths of the stream payloads
  localparam int SYM_W  = 8;
  localparam int OCC_W  = 24;
  localparam logic [OCC_W-1:0] OCC_MAX = 24'hFF_FFFF;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CNT_WR = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // Control of the shared selection unit
  typedef struct packed {
    logic start;       // forget the previous best candidate
    logic cand_valid;  // a table entry is presented this cycle
    logic started;     // read cursor holds a previously emitted entry
  } pick_ctrl_t;

endpackage

@@ rtl/core/bhs_table.sv @@
// ---------------------------------------------------------------------------
// bhs_table
// Counter memory with one read and one write port and per-entry valid bits.
// An entry that was never written since the last clear reads as zero.
// ---------------------------------------------------------------------------
module bhs_table #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_WIDTH = 24,
  parameter int ADDR_W      = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clr,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output logic [COUNT_WIDTH-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  logic [COUNT_WIDTH-1:0] wr_data
);

  logic [COUNT_WIDTH-1:0] mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld;
  logic [COUNT_WIDTH-1:0] mem_q;
  logic                   vld_q;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: drop all at once on clear or reset
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

@@ rtl/core/bhs_pick.sv @@
// ---------------------------------------------------------------------------
// bhs_pick
// Shared compare unit: keeps the smallest entry that follows the read cursor,
// ties going to the larger byte value, over one table walk.
// ---------------------------------------------------------------------------
module bhs_pick #(
  parameter int COUNT_WIDTH = 24,
  parameter int ADDR_W      = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bhs_pkg::pick_ctrl_t        ctrl,
  input  logic [COUNT_WIDTH-1:0]     cand_count,
  input  logic [ADDR_W-1:0]          cand_sym,
  input  logic [COUNT_WIDTH-1:0]     last_count,
  input  logic [ADDR_W-1:0]          last_sym,
  output logic                       found,
  output logic [COUNT_WIDTH-1:0]     best_count,
  output logic [ADDR_W-1:0]          best_sym
);

  import bhs_pkg::*;

  logic eligible;
  logic better;

  // Candidate must be nonzero and lie after the cursor
  assign eligible = (cand_count != '0) &&
                    (!ctrl.started || (cand_count > last_count) ||
                     ((cand_count == last_count) && (cand_sym < last_sym)));

  // Candidate beats the current best
  assign better = !found || (cand_count < best_count) ||
                  ((cand_count == best_count) && (cand_sym > best_sym));

  // Track whether any entry qualified
  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      found <= 1'b0;
    end else if (ctrl.cand_valid && eligible) begin
      found <= 1'b1;
    end
  end

  // Hold the best entry so far
  always_ff @(posedge clk) begin
    if (ctrl.cand_valid && eligible && better) begin
      best_count <= cand_count;
      best_sym   <= cand_sym;
    end
  end

endmodule

@@ rtl/core/byte_histogram_sorted_readout_core.sv @@
// ---------------------------------------------------------------------------
// byte_histogram_sorted_readout_core
// Byte frequency table with read-out in ascending count order.
// ---------------------------------------------------------------------------
// Input stream: s_tuser carries the command (count, read, clear), s_tdata
// the byte to count. The core takes one command at a time; s_tready is high
// only while the sequencer is idle.
// A count command does one memory read and then one saturating write back.
// A clear command drops the valid bits of the table at once.
// A read command walks every table entry through one shared compare unit,
// one entry per cycle; the single memory read port sets this rate.
// Output stream: m_tdata holds symbol and occurrences, m_tuser the done flag.
// The result sits in an output register; count and clear commands are
// still taken while it waits. A stalled receiver holds a finished read in
// its last step until the register is free.
// Reset empties the table and the read cursor and drops m_tvalid; it needs
// no clearing pass.
// ---------------------------------------------------------------------------
module byte_histogram_sorted_readout_core #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  bhs_pkg::cmd_t         s_tuser,   // [1:0] command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [7:0] symbol, [31:8] occurrences
  output logic [0:0]            m_tuser    // [0] done_res
);

  import bhs_pkg::*;

  localparam int ADDR_W = $clog2(NUM_SYMBOLS);
  localparam logic [ADDR_W:0] LAST_CNT = (ADDR_W + 1)'(NUM_SYMBOLS);

  state_t state, state_next;

  logic                   accept;
  logic                   byte_in_range;
  logic                   issue;
  logic [ADDR_W:0]        issue_cnt;
  logic                   rd_live;
  logic [ADDR_W-1:0]      rd_sym;
  logic [ADDR_W-1:0]      cnt_addr;
  logic                   started;
  logic [COUNT_WIDTH-1:0] last_count;
  logic [ADDR_W-1:0]      last_sym;

  logic                   tbl_rd_en;
  logic [ADDR_W-1:0]      tbl_rd_addr;
  logic [COUNT_WIDTH-1:0] tbl_rd_data;
  logic                   tbl_wr_en;
  logic [COUNT_WIDTH-1:0] tbl_wr_data;
  logic                   tbl_clr;

  pick_ctrl_t             pick_ctrl;
  logic                   found;
  logic [COUNT_WIDTH-1:0] best_count;
  logic [ADDR_W-1:0]      best_sym;
  logic [31:0]            best_ext;
  logic [OCC_W-1:0]       occ;
  logic                   out_free;

  assign s_tready      = (state == ST_IDLE);
  assign accept        = s_tvalid && s_tready;
  assign byte_in_range = {1'b0, s_tdata} < 9'(NUM_SYMBOLS);
  assign issue         = (state == ST_SCAN) && (issue_cnt < LAST_CNT);
  assign out_free      = !m_tvalid || m_tready;

  // Table port control
  assign tbl_clr     = accept && (s_tuser == CMD_CLEAR);
  assign tbl_rd_en   = (accept && (s_tuser == CMD_COUNT) && byte_in_range) || issue;
  assign tbl_rd_addr = (state == ST_IDLE) ? s_tdata[ADDR_W-1:0]
                                          : issue_cnt[ADDR_W-1:0];
  assign tbl_wr_en   = (state == ST_CNT_WR);
  assign tbl_wr_data = (tbl_rd_data == {COUNT_WIDTH{1'b1}}) ? tbl_rd_data
                                                           : tbl_rd_data + COUNT_WIDTH'(1);

  bhs_table #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .clr     (tbl_clr),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (cnt_addr),
    .wr_data (tbl_wr_data)
  );

  // Selection unit control
  assign pick_ctrl.start      = accept && (s_tuser == CMD_READ);
  assign pick_ctrl.cand_valid = rd_live;
  assign pick_ctrl.started    = started;

  bhs_pick #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_pick (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pick_ctrl),
    .cand_count (tbl_rd_data),
    .cand_sym   (rd_sym),
    .last_count (last_count),
    .last_sym   (last_sym),
    .found      (found),
    .best_count (best_count),
    .best_sym   (best_sym)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == CMD_COUNT) && byte_in_range) begin
          state_next = ST_CNT_WR;
        end else if (accept && (s_tuser == CMD_READ)) begin
          state_next = ST_SCAN;
        end
      end
      ST_CNT_WR: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if ((issue_cnt == LAST_CNT) && !rd_live) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk counter and read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_live   <= 1'b0;
    end else begin
      rd_live <= issue;
      if (pick_ctrl.start) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + (ADDR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sym <= issue_cnt[ADDR_W-1:0];
    if (accept) begin
      cnt_addr <= s_tdata[ADDR_W-1:0];
    end
  end

  // Read cursor: restart on count or clear, advance on a found entry
  always_ff @(posedge clk) begin
    if (rst || (accept && ((s_tuser == CMD_COUNT) || (s_tuser == CMD_CLEAR)))) begin
      started    <= 1'b0;
      last_count <= '0;
      last_sym   <= '0;
    end else if ((state == ST_FINISH) && out_free && found) begin
      started    <= 1'b1;
      last_count <= best_count;
      last_sym   <= best_sym;
    end
  end

  // Clamp the count to the occurrences field
  assign best_ext = 32'(best_count);
  assign occ      = (best_ext > 32'(OCC_MAX)) ? OCC_MAX : best_ext[OCC_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      m_tdata <= found ? {occ, SYM_W'(best_sym)} : '0;
      m_tuser <= found ? 1'b0 : 1'b1;
    end
  end

endmodule

@@ rtl/core/bhs_checker.sv @@
// ---------------------------------------------------------------------------
// bhs_checker
// Port-level checks of the sorted byte histogram core, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bhs_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input bhs_pkg::cmd_t s_tuser,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [31:0]   m_tdata,
  input logic [0:0]    m_tuser
);

  import bhs_pkg::*;

  // No result survives a reset
  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, !rst && $past(rst) |-> !m_tvalid, "result valid after reset")

  // A stalled result holds its payload
  `CHK_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // The done answer carries zero symbol and count
  `CHK_ASSERT(a_done_zero, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata == 32'd0, "done result not zero")

  // A read occupies the core: no transfer in the next cycle
  `CHK_ASSERT(a_read_busy, clk, rst, s_tvalid && s_tready && s_tuser == CMD_READ |=> !s_tready, "ready right after read")

  // A read never yields a result in the following cycle
  `CHK_ASSERT(a_read_lat, clk, rst, s_tvalid && s_tready && s_tuser == CMD_READ && !m_tvalid |=> !m_tvalid, "read answered too early")

endmodule

bind byte_histogram_sorted_readout_core bhs_checker u_bhs_checker (.*);
